/* sv/four_voice_sample_mixer_assert.svh */
// Assertion macros for the four-voice sample mixer.
`ifndef FOUR_VOICE_SAMPLE_MIXER_ASSERT_SVH
`define FOUR_VOICE_SAMPLE_MIXER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define FVSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define FVSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FVSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define FVSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/fvsm_pkg.sv */
// Shared constants and types for the four-voice sample mixer.
package fvsm_pkg;

  localparam int FRACTION_BITS    = 12;
  localparam int SAMPLE_ADDR_BITS = 16;
  localparam int PITCH_ENTRIES    = 1024;
  localparam int VOICES           = 4;
  localparam int PI_W             = $clog2(PITCH_ENTRIES);
  localparam int VI_W             = $clog2(VOICES);
  localparam int ACC_W            = 24;
  localparam int ACC_CW           = $clog2(ACC_W);
  localparam int OUT_MAX          = 16383;
  localparam int OUT_MIN          = -16384;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_NOTE         = 3'd1,
    OP_PITCH        = 3'd2,
    OP_VOLUME       = 3'd3,
    OP_POSITION     = 3'd4,
    OP_WRITE_SAMPLE = 3'd5,
    OP_WRITE_STEP   = 3'd6,
    OP_NONE         = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_SILENT = 2'd0,
    MODE_PLAY   = 2'd1,
    MODE_REPEAT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SUB,
    ST_FETCH,
    ST_ADD,
    ST_MOD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  channel;
    logic [9:0]  pitch;
    logic        sample_present;
    logic [15:0] sample_base;
    logic [16:0] sample_length;
    logic        loop_present;
    logic [15:0] loop_base;
    logic [16:0] loop_length;
  } item_t;

endpackage

/* sv/fvsm_stream_if.sv */
// Channel interfaces: input items, mixed results and the oversample register.
interface fvsm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [1:0]  channel;
  logic [9:0]  pitch;
  logic [6:0]  volume;
  logic        sample_present;
  logic [15:0] sample_base;
  logic [16:0] sample_length;
  logic        loop_present;
  logic [15:0] loop_base;
  logic [16:0] loop_length;
  logic [15:0] address;
  logic [31:0] data;
  modport source (output valid, operation, channel, pitch, volume, sample_present,
                  sample_base, sample_length, loop_present, loop_base, loop_length,
                  address, data, input ready);
  modport sink (input valid, operation, channel, pitch, volume, sample_present,
                sample_base, sample_length, loop_present, loop_base, loop_length,
                address, data, output ready);
endinterface

interface fvsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] left;
  logic signed [14:0] right;
  modport source (output valid, left, right, input ready);
  modport sink (input valid, left, right, output ready);
endinterface

interface fvsm_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] oversample;
  modport source (output valid, oversample, input ready);
  modport sink (input valid, oversample, output ready);
endinterface

/* sv/four_voice_sample_mixer.sv */
// Four-voice sample mixer: sequencer, voice state, sample and step memories.
// Tick: per voice n sub-steps (n = oversample, 0 taken as 1) of SUB, FETCH, ADD (SUB, ADD when
//   silent; SUB again on entering the loop, MOD per wrap past the loop end); then DIV and OUT,
//   which holds while an earlier result is not taken. Note and pitch pass STEP; others stay IDLE.
// Reset (rst_n low, synchronous): voices silent, all voice fields zero, oversample 1;
//   sample and step memories are not cleared. One item at a time.
`include "four_voice_sample_mixer_assert.svh"
module four_voice_sample_mixer (
  input  logic clk,
  input  logic rst_n,
  fvsm_in_if.sink    in_ch,
  fvsm_out_if.source out_ch,
  fvsm_cfg_if.sink   cfg_ch
);

  localparam int FB  = fvsm_pkg::FRACTION_BITS;
  localparam int SAW = fvsm_pkg::SAMPLE_ADDR_BITS;
  localparam int NV  = fvsm_pkg::VOICES;
  localparam int AW  = fvsm_pkg::ACC_W;

  fvsm_pkg::state_t state_r, state_nxt;
  fvsm_pkg::item_t  item_r, item_nxt;

  // voice state
  fvsm_pkg::mode_t mode_r [NV];
  fvsm_pkg::mode_t mode_nxt [NV];
  logic [31:0] ptr_r [NV];
  logic [31:0] ptr_nxt [NV];
  logic [31:0] step_r [NV];
  logic [31:0] step_nxt [NV];
  logic [6:0]  vol_r [NV];
  logic [6:0]  vol_nxt [NV];
  logic [15:0] sbase_r [NV];
  logic [15:0] sbase_nxt [NV];
  logic [16:0] slen_r [NV];
  logic [16:0] slen_nxt [NV];
  logic        lpres_r [NV];
  logic        lpres_nxt [NV];
  logic [15:0] lbase_r [NV];
  logic [15:0] lbase_nxt [NV];
  logic [16:0] llen_r [NV];
  logic [16:0] llen_nxt [NV];

  logic [4:0] oversample_r, oversample_nxt;

  // tick sequencing
  logic [fvsm_pkg::VI_W-1:0] v_r, v_nxt;
  logic [4:0] s_r, s_nxt;
  logic [4:0] n_r, n_nxt;
  logic signed [AW-1:0] accl_r, accl_nxt, accr_r, accr_nxt;
  logic signed [15:0] prod_r, prod_nxt;
  logic step_ok_r, step_ok_nxt;

  // pointer modulo unit
  logic [31:0] mrem_r, mrem_nxt, mdvd_r, mdvd_nxt;
  logic [4:0]  mcnt_r, mcnt_nxt;

  // output divide unit (left and right side by side)
  logic [AW-1:0] dql_r, dql_nxt, dqr_r, dqr_nxt;
  logic [4:0] dreml_r, dreml_nxt, dremr_r, dremr_nxt;
  logic dsgnl_r, dsgnl_nxt, dsgnr_r, dsgnr_nxt;
  logic [fvsm_pkg::ACC_CW-1:0] dcnt_r, dcnt_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic signed [14:0] out_left_r, out_left_nxt, out_right_r, out_right_nxt;

  // memories
  logic [7:0]  sample_mem [2**SAW];
  logic [31:0] step_mem [fvsm_pkg::PITCH_ENTRIES];
  logic [7:0]  sample_q;
  logic [31:0] step_q;
  logic [SAW-1:0] s_raddr;
  logic s_we, t_we;
  logic [fvsm_pkg::PI_W-1:0] t_addr;

  logic in_fire;
  logic pitch_ok;
  fvsm_pkg::op_t in_op;

  // current voice views and helpers
  logic [31:0] cur_ptr, len32, rlen32;
  logic [32:0] mshift;
  logic [5:0]  lshift, rshift;
  logic last_sub;
  logic signed [AW:0] ql_s, qr_s;

  assign in_ch.ready  = (state_r == fvsm_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.left  = out_left_r;
  assign out_ch.right = out_right_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_op    = fvsm_pkg::op_t'(in_ch.operation);
  assign pitch_ok = (32'(in_ch.pitch) < 32'(fvsm_pkg::PITCH_ENTRIES));
  assign t_addr   = fvsm_pkg::PI_W'(in_ch.pitch);
  assign t_we     = in_fire && (in_op == fvsm_pkg::OP_WRITE_STEP) && pitch_ok;
  assign s_we     = in_fire && (in_op == fvsm_pkg::OP_WRITE_SAMPLE);

  assign cur_ptr  = ptr_r[v_r];
  assign len32    = 32'(slen_r[v_r]) << FB;
  assign rlen32   = 32'(llen_r[v_r]) << FB;
  assign mshift   = {mrem_r, mdvd_r[31]};
  assign lshift   = {dreml_r, dql_r[AW-1]};
  assign rshift   = {dremr_r, dqr_r[AW-1]};
  assign last_sub = (s_r == n_r - 5'd1);
  assign ql_s     = dsgnl_r ? -$signed({1'b0, dql_r}) : $signed({1'b0, dql_r});
  assign qr_s     = dsgnr_r ? -$signed({1'b0, dqr_r}) : $signed({1'b0, dqr_r});

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (s_we) begin
      sample_mem[SAW'(in_ch.address)] <= in_ch.data[7:0];
    end
    sample_q <= sample_mem[s_raddr];
  end

  // step table memory
  always_ff @(posedge clk) begin
    if (t_we) begin
      step_mem[t_addr] <= in_ch.data;
    end
    step_q <= step_mem[t_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fvsm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_op == fvsm_pkg::OP_TICK) state_nxt = fvsm_pkg::ST_SUB;
          else if (in_op == fvsm_pkg::OP_NOTE || in_op == fvsm_pkg::OP_PITCH)
            state_nxt = fvsm_pkg::ST_STEP;
        end
      end
      fvsm_pkg::ST_STEP: state_nxt = fvsm_pkg::ST_IDLE;
      fvsm_pkg::ST_SUB: begin
        case (mode_r[v_r])
          fvsm_pkg::MODE_PLAY: begin
            if (cur_ptr < len32) state_nxt = fvsm_pkg::ST_FETCH;
          end
          fvsm_pkg::MODE_REPEAT: begin
            if (!lpres_r[v_r] || llen_r[v_r] == '0) state_nxt = fvsm_pkg::ST_ADD;
            else if (cur_ptr >= rlen32) state_nxt = fvsm_pkg::ST_MOD;
            else state_nxt = fvsm_pkg::ST_FETCH;
          end
          default: state_nxt = fvsm_pkg::ST_ADD;
        endcase
      end
      fvsm_pkg::ST_FETCH: state_nxt = fvsm_pkg::ST_ADD;
      fvsm_pkg::ST_ADD: begin
        if (last_sub && v_r == fvsm_pkg::VI_W'(NV - 1)) state_nxt = fvsm_pkg::ST_DIV;
        else state_nxt = fvsm_pkg::ST_SUB;
      end
      fvsm_pkg::ST_MOD: begin
        if (mcnt_r == 5'd31) state_nxt = fvsm_pkg::ST_SUB;
      end
      fvsm_pkg::ST_DIV: begin
        if (dcnt_r == fvsm_pkg::ACC_CW'(AW - 1)) state_nxt = fvsm_pkg::ST_OUT;
      end
      fvsm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = fvsm_pkg::ST_IDLE;
      end
      default: state_nxt = fvsm_pkg::ST_IDLE;
    endcase
  end

  // datapath and register updates
  always_comb begin
    item_nxt       = item_r;
    mode_nxt       = mode_r;
    ptr_nxt        = ptr_r;
    step_nxt       = step_r;
    vol_nxt        = vol_r;
    sbase_nxt      = sbase_r;
    slen_nxt       = slen_r;
    lpres_nxt      = lpres_r;
    lbase_nxt      = lbase_r;
    llen_nxt       = llen_r;
    oversample_nxt = oversample_r;
    v_nxt          = v_r;
    s_nxt          = s_r;
    n_nxt          = n_r;
    accl_nxt       = accl_r;
    accr_nxt       = accr_r;
    prod_nxt       = prod_r;
    step_ok_nxt    = step_ok_r;
    mrem_nxt       = mrem_r;
    mdvd_nxt       = mdvd_r;
    mcnt_nxt       = mcnt_r;
    dql_nxt        = dql_r;
    dqr_nxt        = dqr_r;
    dreml_nxt      = dreml_r;
    dremr_nxt      = dremr_r;
    dsgnl_nxt      = dsgnl_r;
    dsgnr_nxt      = dsgnr_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    s_raddr        = SAW'(sbase_r[v_r]) + SAW'(cur_ptr >> FB);

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (cfg_ch.valid) oversample_nxt = cfg_ch.oversample;

    case (state_r)
      fvsm_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_nxt = '{operation: in_ch.operation, channel: in_ch.channel,
                       pitch: in_ch.pitch, sample_present: in_ch.sample_present,
                       sample_base: in_ch.sample_base, sample_length: in_ch.sample_length,
                       loop_present: in_ch.loop_present, loop_base: in_ch.loop_base,
                       loop_length: in_ch.loop_length};
          step_ok_nxt = pitch_ok;
          case (in_op)
            fvsm_pkg::OP_TICK: begin
              v_nxt    = '0;
              s_nxt    = '0;
              n_nxt    = (oversample_r == '0) ? 5'd1 : oversample_r;
              accl_nxt = '0;
              accr_nxt = '0;
            end
            fvsm_pkg::OP_VOLUME:   vol_nxt[in_ch.channel] = in_ch.volume;
            fvsm_pkg::OP_POSITION: ptr_nxt[in_ch.channel] = 32'(in_ch.address) << FB;
            default: ;
          endcase
        end
      end
      // step table answer arrives: finish note or pitch change
      fvsm_pkg::ST_STEP: begin
        step_nxt[item_r.channel] = step_ok_r ? step_q : '0;
        if (fvsm_pkg::op_t'(item_r.operation) == fvsm_pkg::OP_NOTE) begin
          ptr_nxt[item_r.channel] = '0;
          if (item_r.sample_present) begin
            sbase_nxt[item_r.channel] = item_r.sample_base;
            slen_nxt[item_r.channel]  = item_r.sample_length;
            lpres_nxt[item_r.channel] = item_r.loop_present;
            lbase_nxt[item_r.channel] = item_r.loop_base;
            llen_nxt[item_r.channel]  = item_r.loop_length;
            mode_nxt[item_r.channel]  = fvsm_pkg::MODE_PLAY;
          end else begin
            mode_nxt[item_r.channel] = fvsm_pkg::MODE_SILENT;
          end
        end
      end
      // one sub-step decision for the current voice
      fvsm_pkg::ST_SUB: begin
        case (mode_r[v_r])
          fvsm_pkg::MODE_PLAY: begin
            if (cur_ptr < len32) begin
              ptr_nxt[v_r] = cur_ptr + step_r[v_r];
            end else begin
              mode_nxt[v_r] = fvsm_pkg::MODE_REPEAT;
              ptr_nxt[v_r]  = cur_ptr - len32;
            end
          end
          fvsm_pkg::MODE_REPEAT: begin
            if (!lpres_r[v_r] || llen_r[v_r] == '0) begin
              mode_nxt[v_r] = fvsm_pkg::MODE_SILENT;
              prod_nxt      = '0;
            end else if (cur_ptr >= rlen32) begin
              mrem_nxt = '0;
              mdvd_nxt = cur_ptr;
              mcnt_nxt = '0;
            end else begin
              s_raddr      = SAW'(lbase_r[v_r]) + SAW'(cur_ptr >> FB);
              ptr_nxt[v_r] = cur_ptr + step_r[v_r];
            end
          end
          default: begin
            mode_nxt[v_r] = fvsm_pkg::MODE_SILENT;
            prod_nxt      = '0;
          end
        endcase
      end
      // scale the fetched byte
      fvsm_pkg::ST_FETCH: begin
        prod_nxt = $signed(sample_q) * $signed({1'b0, vol_r[v_r]});
      end
      // accumulate and advance sub-step / voice
      fvsm_pkg::ST_ADD: begin
        if (v_r == fvsm_pkg::VI_W'(0) || v_r == fvsm_pkg::VI_W'(3))
          accl_nxt = accl_r + AW'(prod_r);
        else
          accr_nxt = accr_r + AW'(prod_r);
        if (last_sub) begin
          s_nxt = '0;
          v_nxt = v_r + 1'b1;
        end else begin
          s_nxt = s_r + 5'd1;
        end
        // set up the divide from the final sums
        if (last_sub && v_r == fvsm_pkg::VI_W'(NV - 1)) begin
          dsgnl_nxt = accl_nxt[AW-1];
          dsgnr_nxt = accr_nxt[AW-1];
          dql_nxt   = accl_nxt[AW-1] ? AW'(-accl_nxt) : AW'(accl_nxt);
          dqr_nxt   = accr_nxt[AW-1] ? AW'(-accr_nxt) : AW'(accr_nxt);
          dreml_nxt = '0;
          dremr_nxt = '0;
          dcnt_nxt  = '0;
        end
      end
      // restoring remainder, one bit a cycle
      fvsm_pkg::ST_MOD: begin
        mdvd_nxt = mdvd_r << 1;
        mcnt_nxt = mcnt_r + 5'd1;
        if (mshift >= {1'b0, rlen32}) mrem_nxt = 32'(mshift - {1'b0, rlen32});
        else mrem_nxt = mshift[31:0];
        if (mcnt_r == 5'd31) ptr_nxt[v_r] = mrem_nxt;
      end
      // restoring divide of both magnitudes by n
      fvsm_pkg::ST_DIV: begin
        dcnt_nxt = dcnt_r + 1'b1;
        if (lshift >= {1'b0, n_r}) begin
          dreml_nxt = 5'(lshift - {1'b0, n_r});
          dql_nxt   = {dql_r[AW-2:0], 1'b1};
        end else begin
          dreml_nxt = lshift[4:0];
          dql_nxt   = {dql_r[AW-2:0], 1'b0};
        end
        if (rshift >= {1'b0, n_r}) begin
          dremr_nxt = 5'(rshift - {1'b0, n_r});
          dqr_nxt   = {dqr_r[AW-2:0], 1'b1};
        end else begin
          dremr_nxt = rshift[4:0];
          dqr_nxt   = {dqr_r[AW-2:0], 1'b0};
        end
      end
      // saturate and load the output register
      fvsm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (ql_s > (AW+1)'(fvsm_pkg::OUT_MAX)) out_left_nxt = 15'(fvsm_pkg::OUT_MAX);
          else if (ql_s < (AW+1)'(fvsm_pkg::OUT_MIN)) out_left_nxt = 15'(fvsm_pkg::OUT_MIN);
          else out_left_nxt = 15'(ql_s);
          if (qr_s > (AW+1)'(fvsm_pkg::OUT_MAX)) out_right_nxt = 15'(fvsm_pkg::OUT_MAX);
          else if (qr_s < (AW+1)'(fvsm_pkg::OUT_MIN)) out_right_nxt = 15'(fvsm_pkg::OUT_MIN);
          else out_right_nxt = 15'(qr_s);
        end
      end
      default: ;
    endcase
  end

  // control and voice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fvsm_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      oversample_r <= 5'd1;
      for (int i = 0; i < NV; i++) begin
        mode_r[i]  <= fvsm_pkg::MODE_SILENT;
        ptr_r[i]   <= '0;
        step_r[i]  <= '0;
        vol_r[i]   <= '0;
        sbase_r[i] <= '0;
        slen_r[i]  <= '0;
        lpres_r[i] <= 1'b0;
        lbase_r[i] <= '0;
        llen_r[i]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      oversample_r <= oversample_nxt;
      mode_r       <= mode_nxt;
      ptr_r        <= ptr_nxt;
      step_r       <= step_nxt;
      vol_r        <= vol_nxt;
      sbase_r      <= sbase_nxt;
      slen_r       <= slen_nxt;
      lpres_r      <= lpres_nxt;
      lbase_r      <= lbase_nxt;
      llen_r       <= llen_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    v_r         <= v_nxt;
    s_r         <= s_nxt;
    n_r         <= n_nxt;
    accl_r      <= accl_nxt;
    accr_r      <= accr_nxt;
    prod_r      <= prod_nxt;
    step_ok_r   <= step_ok_nxt;
    mrem_r      <= mrem_nxt;
    mdvd_r      <= mdvd_nxt;
    mcnt_r      <= mcnt_nxt;
    dql_r       <= dql_nxt;
    dqr_r       <= dqr_nxt;
    dreml_r     <= dreml_nxt;
    dremr_r     <= dremr_nxt;
    dsgnl_r     <= dsgnl_nxt;
    dsgnr_r     <= dsgnr_nxt;
    dcnt_r      <= dcnt_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  // checks
  `FVSM_ASSERT_NOW(a_mod_nonzero, clk, rst_n, state_r == fvsm_pkg::ST_MOD, rlen32 != '0, "modulo by zero loop length")
  `FVSM_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_r == fvsm_pkg::ST_DIV, n_r != '0, "divide by zero sub-step count")
  `FVSM_ASSERT_NXT(a_tick_starts, clk, rst_n, in_fire && in_op == fvsm_pkg::OP_TICK, state_r == fvsm_pkg::ST_SUB, "tick did not start mixing")
  `FVSM_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid_r), $past(state_r) == fvsm_pkg::ST_OUT, "result appeared outside output step")

endmodule
